>>> src/piecewise_linear_rate_lookup_macros.svh
// Assertion macros shared by the checker files.
`ifndef PIECEWISE_LINEAR_RATE_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_RATE_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLRL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plrl: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PLRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plrl: next-cycle check failed");

`endif

>>> src/plrl_pkg.sv
// ----------------------------------------------------------------------------
// plrl_pkg
// Types and constants of the piecewise-linear rate lookup.
// ----------------------------------------------------------------------------
package plrl_pkg;

    localparam int DIST_W  = 24;
    localparam int RATE_W  = 40;
    localparam int ENTRY_W = DIST_W + RATE_W;
    localparam int PROD_W  = DIST_W + RATE_W;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] key;
        logic [RATE_W-1:0] rate;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_Q_RD0,
        S_Q_CHK0,
        S_Q_CHKL,
        S_Q_RD,
        S_Q_SCAN,
        S_Q_GO,
        S_Q_WAIT,
        S_CLAMP,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

    // request to the multiply/divide unit
    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] off;
        logic [DIST_W-1:0] span;
        logic [RATE_W-1:0] delta;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quot;
    } t_md_rsp;

endpackage

>>> src/piecewise_linear_rate_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_rate_lookup
// Sorted (distance, rate) breakpoint table with linear interpolation.
// ----------------------------------------------------------------------------
// One transaction at a time. Clear, refused insert, unused opcode and a
// query of an empty table go straight to the result. Insert moves up each
// stored entry above the insertion point, one read and one write per entry
// through the single table read port, then writes the new entry. A query
// checks both ends, then walks the breakpoints, then runs the serial
// multiply (24 steps) and divide (64 steps) unit, then clamps and registers
// the result. The input is taken again in the cycle after the result is
// registered, also while that result still waits on a stalled output. The
// table needs no clearing pass.
module piecewise_linear_rate_lookup
    import plrl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [DIST_W-1:0] i_distance,
    input  logic [RATE_W-1:0] i_entry_rate,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RATE_W-1:0] o_rate,
    output logic              o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [1:0]        r_op;
    logic [DIST_W-1:0] r_dist;
    logic [RATE_W-1:0] r_erate;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    t_entry            r_prev;
    logic [RATE_W-1:0] r_raw;
    logic              r_neg;
    logic [DIST_W-1:0] r_off;
    logic [DIST_W-1:0] r_span;
    logic [RATE_W-1:0] r_delta;
    logic [RATE_W-1:0] r_res_rate;
    logic              r_res_status;
    logic              r_out_valid;
    logic [RATE_W-1:0] r_rate;
    logic              r_status;

    logic              in_acc;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    t_entry            rd;
    logic [CW-1:0]     idx_dec;
    t_md_req           md_req;
    t_md_rsp           md_rsp;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign idx_dec  = r_idx - CW'(1);

    plrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    plrl_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_INSERT && r_count != '0
                        && r_count != CW'(TABLE_DEPTH)) begin
                        n_state = S_INS_RD;
                    end else if (i_opcode == OP_INSERT && r_count == '0) begin
                        n_state = S_INS_PUT;
                    end else if (i_opcode == OP_QUERY && r_count != '0) begin
                        n_state = S_Q_RD0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_INS_RD:  n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (rd.key > r_dist) begin
                    n_state = (idx_dec == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_INS_PUT: n_state = S_FIN;
            S_Q_RD0:   n_state = S_Q_CHK0;
            S_Q_CHK0:  n_state = S_Q_CHKL;
            S_Q_CHKL: begin
                if (r_dist <= r_prev.key || r_dist >= rd.key) begin
                    n_state = S_CLAMP;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_RD:    n_state = S_Q_SCAN;
            S_Q_SCAN:  n_state = (r_dist <= rd.key) ? S_Q_GO : S_Q_RD;
            S_Q_GO:    n_state = S_Q_WAIT;
            S_Q_WAIT:  if (md_rsp.done) n_state = S_CLAMP;
            S_CLAMP:   n_state = S_FIN;
            S_FIN:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // table port and unit controls
    always_comb begin
        ram_we         = 1'b0;
        ram_waddr      = r_idx[AW-1:0];
        ram_wdata      = '{key: r_dist, rate: r_erate};
        ram_raddr      = '0;
        md_req.start   = (r_state == S_Q_GO);
        md_req.off     = r_off;
        md_req.span    = r_span;
        md_req.delta   = r_delta;
        unique case (r_state)
            S_INS_RD:  ram_raddr = idx_dec[AW-1:0];
            S_INS_CHK: begin
                ram_we = 1'b1;
                if (rd.key > r_dist) begin
                    ram_wdata = rd;
                end
            end
            S_INS_PUT: ram_we = 1'b1;
            S_Q_CHK0:  ram_raddr = AW'(r_count - CW'(1));
            S_Q_RD:    ram_raddr = r_idx[AW-1:0];
            default: begin
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_opcode == OP_CLEAR) begin
                r_count <= '0;
            end else if (r_state == S_INS_PUT
                         || (r_state == S_INS_CHK && !(rd.key > r_dist))) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op         <= i_opcode;
                r_dist       <= i_distance;
                r_erate      <= i_entry_rate;
                r_idx        <= r_count;
                r_res_rate   <= '0;
                r_res_status <= ST_DONE;
                if (i_opcode == OP_INSERT && r_count == CW'(TABLE_DEPTH)) begin
                    r_res_status <= ST_REFUSED;
                end
                if (i_opcode == OP_QUERY && r_count == '0) begin
                    r_res_rate <= RATE_W'(1);
                end
            end
            S_INS_CHK: begin
                if (rd.key > r_dist) begin
                    r_idx <= idx_dec;
                end
            end
            S_Q_CHK0: r_prev <= rd;
            S_Q_CHKL: begin
                r_idx <= CW'(1);
                r_raw <= (r_dist <= r_prev.key) ? r_prev.rate : rd.rate;
            end
            S_Q_SCAN: begin
                if (r_dist <= rd.key) begin
                    r_off  <= r_dist - r_prev.key;
                    r_span <= rd.key - r_prev.key;
                    r_neg  <= (rd.rate < r_prev.rate);
                    r_delta <= (rd.rate < r_prev.rate) ? r_prev.rate - rd.rate
                                                       : rd.rate - r_prev.rate;
                end else begin
                    r_prev <= rd;
                    r_idx  <= r_idx + CW'(1);
                end
            end
            S_Q_WAIT: begin
                if (md_rsp.done) begin
                    r_raw <= r_neg ? r_prev.rate - md_rsp.quot : r_prev.rate + md_rsp.quot;
                end
            end
            S_CLAMP: r_res_rate <= (r_raw == '0) ? RATE_W'(1) : r_raw;
            S_FIN: begin
                if (out_free) begin
                    r_rate   <= (r_op == OP_QUERY) ? r_res_rate : '0;
                    r_status <= r_res_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_rate   = r_rate;
    assign o_status = r_status;

endmodule

>>> src/plrl_ram.sv
// ----------------------------------------------------------------------------
// plrl_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module plrl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/plrl_muldiv.sv
// ----------------------------------------------------------------------------
// plrl_muldiv
// Serial unit: off * delta by shift-add (24 steps), then restoring division
// of the product by span (64 steps).
// ----------------------------------------------------------------------------
module plrl_muldiv
    import plrl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    t_md_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [PROD_W-1:0] r_mcand;
    logic [DIST_W-1:0] r_mplier;
    logic [DIST_W-1:0] r_span;
    logic [DIST_W-1:0] r_rem;
    logic [DIST_W:0]   rem_sh;
    logic              q_bit;
    logic              last_step;

    assign rem_sh    = {r_rem, r_num[PROD_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, r_span});
    assign last_step = (r_cnt == CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_MUL;
            MD_MUL:  if (last_step)   n_state = MD_DIV;
            MD_DIV:  if (last_step)   n_state = MD_DONE;
            MD_DONE: n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.done = (r_state == MD_DONE);
        o_rsp.quot = r_num[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                r_num    <= '0;
                r_mcand  <= PROD_W'(i_req.delta);
                r_mplier <= i_req.off;
                r_span   <= i_req.span;
                r_rem    <= '0;
                r_cnt    <= CNT_W'(DIST_W);
            end
            MD_MUL: begin
                if (r_mplier[0]) begin
                    r_num <= r_num + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[DIST_W-1:1]};
                r_cnt    <= last_step ? CNT_W'(PROD_W) : r_cnt - CNT_W'(1);
            end
            MD_DIV: begin
                // remainder stays below span
                r_rem <= q_bit ? DIST_W'(rem_sh - {1'b0, r_span}) : rem_sh[DIST_W-1:0];
                r_num <= {r_num[PROD_W-2:0], q_bit};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

>>> src/plrl_checker.sv
// ----------------------------------------------------------------------------
// plrl_checker
// Port-level checks on the rate lookup, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_rate_lookup_macros.svh"

module plrl_checker
    import plrl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [RATE_W-1:0] o_rate,
    input logic              o_status
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    `PLRL_ASSERT_IMPLY(a_no_orphan_out, i_clk, i_rst_n, o_valid, r_pending != 2'd0)
    `PLRL_ASSERT_IMPLY(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pending != 2'd3)
    `PLRL_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_acc, o_stall)
    `PLRL_ASSERT_IMPLY(a_refused_no_rate, i_clk, i_rst_n, o_valid && o_status, o_rate == '0)
    `PLRL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rate))

endmodule

bind piecewise_linear_rate_lookup plrl_checker u_plrl_checker (.*);
